### rtl/tcpq_pkg.sv
// shared constants, codes and types of the two-class priority queue
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package tcpq_pkg;

    // queue size and id width
    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // stream field widths
    localparam int ENTRY_W    = 16;
    localparam int SERVED_W   = 16;
    localparam int OCC_W      = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SERVE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WITHDRAW = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef logic [ID_BITS-1:0] t_id;

    // contents of one cell
    typedef struct packed {
        logic valid;
        t_id  id;
        logic pref;
    } t_slot;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
        logic serve;
        logic pref;
        t_id  key;
    } t_chain_ctrl;

    // status gathered from the row of cells
    typedef struct packed {
        logic  any_match;
        logic  match_pref;
        logic  ins_open;
        logic  tail_valid;
        t_slot head;
    } t_chain_stat;

endpackage

### rtl/tcpq_cell.sv
// one slot of the queue: holds an entry, compares the key and shifts with its neighbors
// depends on tcpq_pkg
`timescale 1ns / 1ps

module tcpq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcpq_pkg::t_chain_ctrl i_ctrl,
    input  tcpq_pkg::t_slot      i_left,
    input  tcpq_pkg::t_slot      i_right,
    input  logic                 i_hit_in,
    input  logic                 i_pass_in,
    output tcpq_pkg::t_slot      o_slot,
    output logic                 o_hit_out,
    output logic                 o_pass_out,
    output logic                 o_match_pref
);

    logic            r_valid;
    tcpq_pkg::t_id   r_id;
    logic            r_pref;
    tcpq_pkg::t_slot n_slot;
    logic            w_match;
    logic            w_keep;

    // key compare and insert-point test
    assign w_match      = r_valid && (r_id == i_ctrl.key);
    assign w_keep       = r_valid && (i_ctrl.pref ? r_pref : 1'b1);
    assign o_hit_out    = i_hit_in | w_match;
    assign o_pass_out   = i_pass_in | !w_keep;
    assign o_match_pref = w_match & r_pref;
    assign o_slot       = '{valid: r_valid, id: r_id, pref: r_pref};

    // insert shifts toward the tail, removal pulls from the tail side
    always_comb begin
        n_slot = o_slot;
        if (i_ctrl.ins_en) begin
            if (i_pass_in) begin
                n_slot = i_left;
            end else if (!w_keep) begin
                n_slot = '{valid: 1'b1, id: i_ctrl.key, pref: i_ctrl.pref};
            end
        end else if (i_ctrl.rem_en && (i_hit_in || w_match)) begin
            n_slot = i_right;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_id   <= n_slot.id;
        r_pref <= n_slot.pref;
    end

endmodule

### rtl/tcpq_chain.sv
// row of queue cells with the head at cell 0, neighbor links and status gathering
// depends on tcpq_pkg and tcpq_cell
`timescale 1ns / 1ps

module tcpq_chain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcpq_pkg::t_chain_ctrl i_ctrl,
    output tcpq_pkg::t_chain_stat o_stat
);

    tcpq_pkg::t_slot            w_slot [tcpq_pkg::DEPTH];
    logic [tcpq_pkg::DEPTH:0]   w_hit;
    logic [tcpq_pkg::DEPTH:0]   w_pass;
    logic [tcpq_pkg::DEPTH-1:0] w_mpref;

    // a serve removes from the head
    assign w_hit[0]  = i_ctrl.serve;
    assign w_pass[0] = 1'b0;

    for (genvar g = 0; g < tcpq_pkg::DEPTH; g++) begin : g_cell
        tcpq_pkg::t_slot w_left;
        tcpq_pkg::t_slot w_right;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_slot[g-1];
        end

        if (g == tcpq_pkg::DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_slot[g+1];
        end

        tcpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_hit_in     (w_hit[g]),
            .i_pass_in    (w_pass[g]),
            .o_slot       (w_slot[g]),
            .o_hit_out    (w_hit[g+1]),
            .o_pass_out   (w_pass[g+1]),
            .o_match_pref (w_mpref[g])
        );
    end

    // status seen at the ends of the row
    assign o_stat.any_match  = w_hit[tcpq_pkg::DEPTH];
    assign o_stat.match_pref = |w_mpref;
    assign o_stat.ins_open   = w_pass[tcpq_pkg::DEPTH];
    assign o_stat.tail_valid = w_slot[tcpq_pkg::DEPTH-1].valid;
    assign o_stat.head       = w_slot[0];

endmodule

### rtl/two_class_priority_queue.sv
// two-class priority queue of unique ids: stream handshake, operation decode, result register
// depends on tcpq_pkg and tcpq_chain
`timescale 1ns / 1ps

// Usage
//   Input words arrive on s_axis: tuser carries the operation (insert, serve
//   head, withdraw id, query class), tdata the id and the class for an insert.
//   Every input word yields exactly one result word on m_axis: tuser carries
//   the status, tdata the served id, the class found and the occupancy.
//   Acceptance loads the result into the output register. Throughput is
//   one word per cycle while s_axis_tready stays high: the row of cells
//   compares the id in every slot at once and each slot shifts from its
//   neighbor in the same cycle, so the next word sees the updated queue.
//   s_axis_tready stays high while the output register is empty or being
//   taken; when the receiver holds m_axis_tready low with a result waiting,
//   s_axis_tready drops and the result is held unchanged.
//   Reset (i_rst_n low, synchronous) empties the queue and the output
//   register; nothing else needs initializing.
//   Preferred entries stand ahead of normal ones, each class in arrival order.

module two_class_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // entry_id[15:0], preferred[16], zero[23:17]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // served_id[15:0], found_preferred[16], occupancy[21:17], zero[23:22]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);

    tcpq_pkg::t_chain_ctrl w_ctrl;
    tcpq_pkg::t_chain_stat w_stat;
    logic                  w_accept;
    logic [tcpq_pkg::ENTRY_W-1:0] w_entry;
    logic                  w_pref;

    logic [tcpq_pkg::CNT_W-1:0]    r_count;
    logic [tcpq_pkg::CNT_W-1:0]    n_count;
    logic                          r_out_valid;
    logic [tcpq_pkg::STATUS_W-1:0] r_status;
    logic [tcpq_pkg::STATUS_W-1:0] n_status;
    logic [tcpq_pkg::SERVED_W-1:0] r_served;
    logic [tcpq_pkg::SERVED_W-1:0] n_served;
    logic                          r_fpref;
    logic                          n_fpref;
    logic [tcpq_pkg::OCC_W-1:0]    r_occ;
    logic                          w_ins;
    logic                          w_rem;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_entry       = s_axis_tdata[15:0];
    assign w_pref        = s_axis_tdata[16];

    // operation decode and result
    always_comb begin
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        n_status = tcpq_pkg::ST_OK;
        n_served = '0;
        n_fpref  = 1'b0;
        unique case (s_axis_tuser)
            tcpq_pkg::KIND_INSERT: begin
                if (w_stat.any_match) begin
                    n_status = tcpq_pkg::ST_DUP;
                end else if (w_stat.tail_valid || !w_stat.ins_open) begin
                    n_status = tcpq_pkg::ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            tcpq_pkg::KIND_SERVE: begin
                if (!w_stat.head.valid) begin
                    n_status = tcpq_pkg::ST_EMPTY;
                end else begin
                    w_rem    = 1'b1;
                    n_served = tcpq_pkg::SERVED_W'(w_stat.head.id);
                end
            end
            tcpq_pkg::KIND_WITHDRAW: begin
                if (!w_stat.any_match) begin
                    n_status = tcpq_pkg::ST_NOTFOUND;
                end else begin
                    w_rem = 1'b1;
                end
            end
            default: begin
                if (!w_stat.any_match) begin
                    n_status = tcpq_pkg::ST_NOTFOUND;
                end else begin
                    n_fpref = w_stat.match_pref;
                end
            end
        endcase
    end

    // broadcast to the cells, insert and remove enables gated by the handshake
    assign w_ctrl.ins_en = w_accept && w_ins;
    assign w_ctrl.rem_en = w_accept && w_rem;
    assign w_ctrl.serve  = (s_axis_tuser == tcpq_pkg::KIND_SERVE);
    assign w_ctrl.pref   = w_pref;
    assign w_ctrl.key    = tcpq_pkg::ID_BITS'(w_entry);

    // occupancy after this operation
    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + tcpq_pkg::CNT_W'(1);
        end else if (w_rem) begin
            n_count = r_count - tcpq_pkg::CNT_W'(1);
        end
    end

    tcpq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

    // control state: entry count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_served <= n_served;
            r_fpref  <= n_fpref;
            r_occ    <= tcpq_pkg::OCC_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {2'b00, r_occ, r_fpref, r_served};

endmodule

### rtl/tcpq_checker.sv
// port-level checks of the two-class priority queue, bound to the top level
// depends on tcpq_pkg and two_class_priority_queue
`timescale 1ns / 1ps

module tcpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // input is refused only while a result waits on a stalled receiver
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without output stall");

    // occupancy never exceeds the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:17] <= 5'(tcpq_pkg::DEPTH)))
        else $error("occupancy beyond depth");

    // a failed operation serves nothing and reports no class
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != tcpq_pkg::ST_OK)
        |-> (m_axis_tdata[15:0] == 16'd0) && !m_axis_tdata[16])
        else $error("failed operation carries data");

    // an accepted word shows up next cycle, whether the output register was empty or being taken
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("result word missing after accept");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/two_class_priority_queue_checker.sv
// result checker for the two-class priority queue: watches both stream channels,
// keeps its own copy of the queue and compares every result word with its prediction
// depends on tcpq_pkg
`timescale 1ns / 1ps

module two_class_priority_queue_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [tcpq_pkg::IN_DATA_W-1:0]      i_in_data,   // entry_id[15:0], preferred[16],
                                                             // zero[23:17]
    input  logic [tcpq_pkg::KIND_W-1:0]         i_in_user,   // kind[1:0]
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [tcpq_pkg::OUT_DATA_W-1:0]     i_out_data,  // served_id[15:0],
                                                             // found_preferred[16],
                                                             // occupancy[21:17], zero[23:22]
    input  logic [tcpq_pkg::STATUS_W-1:0]       i_out_user,  // status[2:0]
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked,
    output logic [4:0]                          o_status_seen
);

    // one result word split into its fields
    typedef struct packed {
        logic [tcpq_pkg::STATUS_W-1:0] status;
        tcpq_pkg::t_id                 served_id;
        logic                          found_pref;
        logic [tcpq_pkg::OCC_W-1:0]    occupancy;
    } t_queue_result;

    // shadow queue, head at index 0, preferred entries ahead of normal ones
    tcpq_pkg::t_id shadow_id [tcpq_pkg::DEPTH];
    logic          shadow_pref [tcpq_pkg::DEPTH];
    int            shadow_count;
    t_queue_result results_due [$];

    // position of an id in the shadow queue, -1 when absent
    function automatic int locate_id(tcpq_pkg::t_id id);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_id[i] == id) return i;
        return -1;
    endfunction

    // close the gap left by a removed entry
    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_id[i]   = shadow_id[i + 1];
            shadow_pref[i] = shadow_pref[i + 1];
        end
        shadow_count--;
    endfunction

    // apply one operation to the shadow queue and return the result it yields
    function automatic t_queue_result apply_operation(logic [tcpq_pkg::KIND_W-1:0] kind,
                                                      tcpq_pkg::t_id id, logic pref);
        t_queue_result res;
        int            pos;
        res        = '0;
        res.status = tcpq_pkg::ST_OK;
        case (kind)
            tcpq_pkg::KIND_INSERT: begin
                // a duplicate is reported even when the queue is full
                if (locate_id(id) >= 0) begin
                    res.status = tcpq_pkg::ST_DUP;
                end else if (shadow_count >= tcpq_pkg::DEPTH) begin
                    res.status = tcpq_pkg::ST_FULL;
                end else begin
                    pos = shadow_count;
                    // preferred entry goes right behind the last preferred one
                    if (pref) begin
                        pos = 0;
                        while (pos < shadow_count && shadow_pref[pos]) pos++;
                    end
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_id[i]   = shadow_id[i - 1];
                        shadow_pref[i] = shadow_pref[i - 1];
                    end
                    shadow_id[pos]   = id;
                    shadow_pref[pos] = pref;
                    shadow_count++;
                end
            end
            tcpq_pkg::KIND_SERVE: begin
                if (shadow_count == 0) begin
                    res.status = tcpq_pkg::ST_EMPTY;
                end else begin
                    res.served_id = shadow_id[0];
                    drop_slot(0);
                end
            end
            tcpq_pkg::KIND_WITHDRAW: begin
                pos = locate_id(id);
                if (pos < 0) res.status = tcpq_pkg::ST_NOTFOUND;
                else drop_slot(pos);
            end
            default: begin
                pos = locate_id(id);
                if (pos < 0) res.status = tcpq_pkg::ST_NOTFOUND;
                else res.found_pref = shadow_pref[pos];
            end
        endcase
        res.occupancy = tcpq_pkg::OCC_W'(shadow_count);
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_errors++;
        end
    endfunction

    // sample both channels at the clock edge: results first, then the new operation
    always @(posedge i_clk) begin
        t_queue_result due;
        if (!i_rst_n) begin
            shadow_count  = 0;
            o_status_seen = '0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (i_out_user <= tcpq_pkg::ST_NOTFOUND) o_status_seen[i_out_user] = 1'b1;
                if (results_due.size() == 0) begin
                    $error("result word with no operation waiting: status 0x%0h data 0x%0h",
                           i_out_user, i_out_data);
                    o_errors++;
                end else begin
                    due = results_due.pop_front();
                    compare_field("status", 32'(due.status), 32'(i_out_user));
                    compare_field("served_id", 32'(due.served_id),
                                  32'(i_out_data[tcpq_pkg::SERVED_W-1:0]));
                    compare_field("found_preferred", 32'(due.found_pref),
                                  32'(i_out_data[tcpq_pkg::SERVED_W]));
                    compare_field("occupancy", 32'(due.occupancy),
                                  32'(i_out_data[tcpq_pkg::SERVED_W+tcpq_pkg::OCC_W:
                                                 tcpq_pkg::SERVED_W+1]));
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(apply_operation(i_in_user,
                                                      i_in_data[tcpq_pkg::ENTRY_W-1:0],
                                                      i_in_data[tcpq_pkg::ENTRY_W]));
        end
        o_pending = results_due.size();
    end

endmodule

### tb/two_class_priority_queue_tb.sv
// top of the two-class priority queue testbench: clock, reset, operation stimulus,
// receiver back-pressure and the final verdict
// depends on tcpq_pkg, two_class_priority_queue and two_class_priority_queue_checker
`timescale 1ns / 1ps

module two_class_priority_queue_tb;

    localparam int CLK_HALF      = 2;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BLOCKS = 12;
    localparam int BLOCK_OPS     = 100;
    localparam int POOL_SIZE     = 24;
    localparam int SETTLE_CYCLES = 8;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic [tcpq_pkg::IN_DATA_W-1:0]      s_axis_tdata  = '0;  // entry_id[15:0], preferred[16],
                                                              // zero[23:17]
    logic [tcpq_pkg::KIND_W-1:0]         s_axis_tuser  = '0;  // kind[1:0]
    logic                                m_axis_tready = 1'b0;
    logic                                s_axis_tready;
    logic                                m_axis_tvalid;
    logic [tcpq_pkg::OUT_DATA_W-1:0]     m_axis_tdata;        // served_id[15:0],
                                                              // found_preferred[16],
                                                              // occupancy[21:17], zero[23:22]
    logic [tcpq_pkg::STATUS_W-1:0]       m_axis_tuser;        // status[2:0]

    int            gap_pct     = 25;
    int            stall_pct   = 25;
    int            stall_left  = 0;
    int            cycle_count = 0;
    int            ops_sent    = 0;
    int            error_count;
    int            words_pending;
    int            words_checked;
    logic [4:0]    status_seen;
    tcpq_pkg::t_id id_pool [POOL_SIZE];

    always #(CLK_HALF) i_clk = ~i_clk;

    two_class_priority_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    two_class_priority_queue_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .o_errors      (error_count),
        .o_pending     (words_pending),
        .o_checked     (words_checked),
        .o_status_seen (status_seen)
    );

    // receiver stalls in bursts; each starts with a chance of stall_pct percent and has a random length
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // present one word and hold it until accepted, then maybe leave a gap
    task automatic send_op(logic [tcpq_pkg::KIND_W-1:0] kind, tcpq_pkg::t_id id, logic pref);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(tcpq_pkg::IN_DATA_W - tcpq_pkg::ENTRY_W - 1){1'b0}}, pref, id};
        do @(posedge i_clk); while (!s_axis_tready);
        ops_sent++;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every result has been taken
    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        wait (words_pending == 0);
        @(posedge i_clk);
    endtask

    // mostly ids from a small pool so that duplicates and hits are common
    function automatic tcpq_pkg::t_id pick_id();
        if ($urandom_range(0, 3) == 0) return tcpq_pkg::t_id'($urandom_range(0, 65535));
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial begin
        int                          directed_ops;
        int                          insert_pct;
        int                          sel;
        logic [tcpq_pkg::KIND_W-1:0] kind;

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = tcpq_pkg::t_id'($urandom_range(0, 65535));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: serve, withdraw and query all miss
        send_op(tcpq_pkg::KIND_SERVE, 16'hFFFF, 1'b1);
        send_op(tcpq_pkg::KIND_WITHDRAW, 16'h0000, 1'b0);
        send_op(tcpq_pkg::KIND_QUERY, 16'hFFFF, 1'b0);
        // extreme ids, both classes, duplicate, lookups
        send_op(tcpq_pkg::KIND_INSERT, 16'h0000, 1'b0);
        send_op(tcpq_pkg::KIND_INSERT, 16'hFFFF, 1'b1);
        send_op(tcpq_pkg::KIND_INSERT, 16'h0000, 1'b1);
        send_op(tcpq_pkg::KIND_QUERY, 16'h0000, 1'b1);
        send_op(tcpq_pkg::KIND_QUERY, 16'hFFFF, 1'b0);
        // preferred insert lands behind the last preferred, ahead of normal
        send_op(tcpq_pkg::KIND_INSERT, 16'h1234, 1'b1);
        send_op(tcpq_pkg::KIND_INSERT, 16'h8000, 1'b0);
        send_op(tcpq_pkg::KIND_WITHDRAW, 16'h8000, 1'b1);
        // fill up, then a fresh id is refused and a duplicate wins over full
        for (int i = 0; i < tcpq_pkg::DEPTH - 3; i++)
            send_op(tcpq_pkg::KIND_INSERT, 16'h0100 + tcpq_pkg::t_id'(i), i[0]);
        send_op(tcpq_pkg::KIND_INSERT, 16'h5555, 1'b1);
        send_op(tcpq_pkg::KIND_INSERT, 16'hFFFF, 1'b0);
        directed_ops = ops_sent;
        drain_wait();

        // random blocks rotate through three insert shares so that the queue fills and drains
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            if (b >= RANDOM_BLOCKS - 2 || b % 4 == 3) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(5, 40);
                stall_pct = $urandom_range(5, 40);
            end
            insert_pct = (b % 3 == 0) ? 65 : (b % 3 == 1) ? 40 : 25;
            if (b == 4 || b == 8) drain_wait();
            for (int k = 0; k < BLOCK_OPS; k++) begin
                if ($urandom_range(0, 99) < insert_pct) begin
                    kind = tcpq_pkg::KIND_INSERT;
                end else begin
                    sel  = $urandom_range(0, 2);
                    kind = (sel == 0) ? tcpq_pkg::KIND_SERVE :
                           (sel == 1) ? tcpq_pkg::KIND_WITHDRAW : tcpq_pkg::KIND_QUERY;
                end
                send_op(kind, pick_id(), 1'($urandom_range(0, 1)));
            end
        end

        // let the last results come back
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        wait (words_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Summary: %0d operations sent (%0d directed), %0d result words checked",
                 ops_sent, directed_ops, words_checked);
        $display("Summary: status codes seen, one bit per code from ok upward: %b",
                 status_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
